// ----- hdl/touch_gesture_classifier_top_defines.svh -----
// Assertion macros for the RTL top of the touch gesture classifier.
// All of them sample on i_clk and are switched off while i_rst_n is low.
`ifndef TOUCH_GESTURE_CLASSIFIER_TOP_DEFINES_SVH
`define TOUCH_GESTURE_CLASSIFIER_TOP_DEFINES_SVH

// Same-cycle implication
`define TGC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define TGC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/tgc_pkg.sv -----
package tgc_pkg;

    localparam int COORD_W = 16;
    localparam int TIME_W  = 32;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;

    // Register reset values
    localparam logic [COORD_W-1:0] X_EDGE_RST         = COORD_W'(279);
    localparam logic [COORD_W-1:0] Y_EDGE_RST         = COORD_W'(455);
    localparam logic [CFG_W-1:0]   LONG_PRESS_MS_RST  = CFG_W'(1000);
    localparam logic [CFG_W-1:0]   TAP_MAX_MS_RST     = CFG_W'(300);
    localparam logic [CFG_W-1:0]   TAP_MAX_MOVE_RST   = CFG_W'(20);
    localparam logic [CFG_W-1:0]   SWIPE_MIN_MOVE_RST = CFG_W'(50);

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE         = 3'd0,
        CFG_X_EDGE         = 3'd1,
        CFG_Y_EDGE         = 3'd2,
        CFG_LONG_PRESS_MS  = 3'd3,
        CFG_TAP_MAX_MS     = 3'd4,
        CFG_TAP_MAX_MOVE   = 3'd5,
        CFG_SWIPE_MIN_MOVE = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        GEST_NONE  = 3'd0,
        GEST_TAP   = 3'd1,
        GEST_LONG  = 3'd2,
        GEST_LEFT  = 3'd3,
        GEST_RIGHT = 3'd4,
        GEST_UP    = 3'd5,
        GEST_DOWN  = 3'd6
    } t_gesture;

    typedef struct packed {
        logic               enable;
        logic [COORD_W-1:0] x_edge;
        logic [COORD_W-1:0] y_edge;
        logic [CFG_W-1:0]   long_press_ms;
        logic [CFG_W-1:0]   tap_max_ms;
        logic [CFG_W-1:0]   tap_max_move;
        logic [CFG_W-1:0]   swipe_min_move;
    } t_cfg;

    // Touch tracking state (touching flag is kept apart as control)
    typedef struct packed {
        logic [COORD_W-1:0] first_x;
        logic [COORD_W-1:0] first_y;
        logic [COORD_W-1:0] last_x;
        logic [COORD_W-1:0] last_y;
        logic [TIME_W-1:0]  press_time;
    } t_track;

    typedef struct packed {
        logic               pressed;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [TIME_W-1:0]  now_ms;
    } t_sample;

endpackage

// ----- hdl/tgc_sample_if.sv -----
interface tgc_sample_if import tgc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               pressed;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [TIME_W-1:0]  now_ms;

    modport source (output valid, pressed, pos_x, pos_y, now_ms, input ready);
    modport sink   (input valid, pressed, pos_x, pos_y, now_ms, output ready);
endinterface

// ----- hdl/tgc_result_if.sv -----
interface tgc_result_if import tgc_pkg::*; ();
    logic               valid;
    logic               ready;
    t_gesture           gesture;
    logic               rejected;
    logic [COORD_W-1:0] origin_y;

    modport source (output valid, gesture, rejected, origin_y, input ready);
    modport sink   (input valid, gesture, rejected, origin_y, output ready);
endinterface

// ----- hdl/touch_gesture_classifier_top.sv -----
// Samples pass the input stage, then the result register, which drives the output.
// Throughput: one sample per cycle; the input stage and the result register hold two
// samples, so one more sample is taken while the result waits, then the input stalls.
// Reset (i_rst_n low, synchronous): both stages empty, not touching, tracking state
// zero, registers at their defaults (enabled, bounds 279 x 455, 1000/300/20/50).
`include "touch_gesture_classifier_top_defines.svh"

module touch_gesture_classifier_top import tgc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    tgc_sample_if.sink           i_sample,
    tgc_result_if.source         o_result
);

    t_cfg     r_cfg;
    logic     r_touching;
    logic     n_touching;
    t_track   r_trk;
    t_track   n_trk;

    logic     r_in_valid;
    t_sample  r_in;
    logic     r_out_valid;
    t_gesture r_out_gesture;
    logic     r_out_rejected;
    logic [COORD_W-1:0] r_out_origin_y;

    t_gesture n_gesture;
    logic     n_rejected;
    logic [COORD_W-1:0] n_origin_y;
    t_gesture cls_gesture;
    logic     in_bounds;
    logic     advance;
    logic     in_xfer;

    // Handshake: the input stage moves on when the result register is free or draining
    assign advance          = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_sample.ready   = !r_in_valid || advance;
    assign in_xfer          = i_sample.valid && i_sample.ready;

    assign o_result.valid    = r_out_valid;
    assign o_result.gesture  = r_out_gesture;
    assign o_result.rejected = r_out_rejected;
    assign o_result.origin_y = r_out_origin_y;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable         <= 1'b1;
            r_cfg.x_edge         <= X_EDGE_RST;
            r_cfg.y_edge         <= Y_EDGE_RST;
            r_cfg.long_press_ms  <= LONG_PRESS_MS_RST;
            r_cfg.tap_max_ms     <= TAP_MAX_MS_RST;
            r_cfg.tap_max_move   <= TAP_MAX_MOVE_RST;
            r_cfg.swipe_min_move <= SWIPE_MIN_MOVE_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ENABLE:         r_cfg.enable         <= i_cfg_data[0];
                CFG_X_EDGE:         r_cfg.x_edge         <= i_cfg_data;
                CFG_Y_EDGE:         r_cfg.y_edge         <= i_cfg_data;
                CFG_LONG_PRESS_MS:  r_cfg.long_press_ms  <= i_cfg_data;
                CFG_TAP_MAX_MS:     r_cfg.tap_max_ms     <= i_cfg_data;
                CFG_TAP_MAX_MOVE:   r_cfg.tap_max_move   <= i_cfg_data;
                CFG_SWIPE_MIN_MOVE: r_cfg.swipe_min_move <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in.pressed <= i_sample.pressed;
            r_in.pos_x   <= i_sample.pos_x;
            r_in.pos_y   <= i_sample.pos_y;
            r_in.now_ms  <= i_sample.now_ms;
        end
    end

    tgc_classify u_classify (
        .i_cfg     (r_cfg),
        .i_trk     (r_trk),
        .i_now_ms  (r_in.now_ms),
        .o_gesture (cls_gesture)
    );

    // Open screen bounds: both coordinates above zero and below the edge
    assign in_bounds = (r_in.pos_x != '0) && (r_in.pos_x < r_cfg.x_edge) &&
                       (r_in.pos_y != '0) && (r_in.pos_y < r_cfg.y_edge);

    // Sample decode and state update
    always_comb begin
        n_touching = r_touching;
        n_trk      = r_trk;
        n_gesture  = GEST_NONE;
        n_rejected = 1'b0;
        n_origin_y = '0;
        if (r_cfg.enable) begin
            if (r_in.pressed && !in_bounds) begin
                n_rejected = 1'b1;
            end else if (r_in.pressed) begin
                if (!r_touching) begin
                    n_trk.first_x    = r_in.pos_x;
                    n_trk.first_y    = r_in.pos_y;
                    n_trk.press_time = r_in.now_ms;
                    n_touching       = 1'b1;
                end
                n_trk.last_x = r_in.pos_x;
                n_trk.last_y = r_in.pos_y;
            end else if (r_touching) begin
                n_gesture  = cls_gesture;
                n_origin_y = r_trk.first_y;
                n_touching = 1'b0;
            end
        end
    end

    // Tracking state, updated as each sample leaves the input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_touching <= 1'b0;
            r_trk      <= '0;
        end else if (advance) begin
            r_touching <= n_touching;
            r_trk      <= n_trk;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_gesture  <= n_gesture;
            r_out_rejected <= n_rejected;
            r_out_origin_y <= n_origin_y;
        end
    end

    `TGC_ASSERT_SAME(a_rej_quiet, r_out_valid && r_out_rejected, (r_out_gesture == GEST_NONE) && (r_out_origin_y == '0), "rejected sample carries a gesture")
    `TGC_ASSERT_SAME(a_disabled_quiet, r_out_valid && !r_cfg.enable, (r_out_gesture == GEST_NONE) && !r_out_rejected, "result while disabled is not empty")
    `TGC_ASSERT_NEXT(a_release_ends, advance && r_cfg.enable && r_touching && !r_in.pressed, !r_touching, "release did not end the touch")
    `TGC_ASSERT_SAME(a_start_point, $rose(r_touching), (r_trk.first_x == r_trk.last_x) && (r_trk.first_y == r_trk.last_y), "start point differs from current point on press")

endmodule

// ----- hdl/tgc_classify.sv -----
module tgc_classify import tgc_pkg::*; (
    input  t_cfg              i_cfg,
    input  t_track            i_trk,
    input  logic [TIME_W-1:0] i_now_ms,
    output t_gesture          o_gesture
);

    logic [TIME_W-1:0]  dur;
    logic [COORD_W-1:0] ax;
    logic [COORD_W-1:0] ay;
    logic               still;
    logic               long_ok;
    logic               tap_ok;
    logic               horiz;
    logic               vert;

    // Hold time wraps with the timestamp
    assign dur = i_now_ms - i_trk.press_time;

    // Absolute deltas, last point against start point
    assign ax = (i_trk.last_x >= i_trk.first_x) ? (i_trk.last_x - i_trk.first_x)
                                                : (i_trk.first_x - i_trk.last_x);
    assign ay = (i_trk.last_y >= i_trk.first_y) ? (i_trk.last_y - i_trk.first_y)
                                                : (i_trk.first_y - i_trk.last_y);

    assign still   = (ax < i_cfg.tap_max_move) && (ay < i_cfg.tap_max_move);
    assign long_ok = still && (dur >= TIME_W'(i_cfg.long_press_ms));
    assign tap_ok  = still && (dur < TIME_W'(i_cfg.tap_max_ms));

    // Dominant axis must exceed twice the other one
    assign horiz = ({1'b0, ax} > {ay, 1'b0}) && (ax >= i_cfg.swipe_min_move);
    assign vert  = ({1'b0, ay} > {ax, 1'b0}) && (ay >= i_cfg.swipe_min_move);

    // Priority: long press, tap, horizontal, vertical
    always_comb begin
        if (long_ok) begin
            o_gesture = GEST_LONG;
        end else if (tap_ok) begin
            o_gesture = GEST_TAP;
        end else if (horiz) begin
            o_gesture = (i_trk.last_x > i_trk.first_x) ? GEST_RIGHT : GEST_LEFT;
        end else if (vert) begin
            o_gesture = (i_trk.last_y > i_trk.first_y) ? GEST_DOWN : GEST_UP;
        end else begin
            o_gesture = GEST_NONE;
        end
    end

endmodule

// ----- test/tgc_gesture_checker.sv -----
module tgc_gesture_checker import tgc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    tgc_sample_if                i_sample,
    tgc_result_if                i_result,
    output int                   o_fail_count,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_gesture           gesture;
        logic               rejected;
        logic [COORD_W-1:0] origin_y;
    } t_outcome;

    // Shadow copy of the registers and of the tracking state
    t_cfg     cfg;
    logic     touching;
    t_track   trk;
    t_outcome expected_outcomes[$];
    int       fail_count;

    // Gesture decided on release, in priority order
    function automatic t_gesture classify_release(logic [TIME_W-1:0] now);
        logic [TIME_W-1:0]  held;
        logic [COORD_W-1:0] ax;
        logic [COORD_W-1:0] ay;
        logic               still;
        logic               horiz;
        logic               vert;
        held  = now - trk.press_time;
        ax    = (trk.last_x >= trk.first_x) ? trk.last_x - trk.first_x
                                            : trk.first_x - trk.last_x;
        ay    = (trk.last_y >= trk.first_y) ? trk.last_y - trk.first_y
                                            : trk.first_y - trk.last_y;
        still = (ax < cfg.tap_max_move) && (ay < cfg.tap_max_move);
        // 17-bit compares so that 2*|d| cannot overflow
        horiz = ({1'b0, ax} > {ay, 1'b0}) && (ax >= cfg.swipe_min_move);
        vert  = ({1'b0, ay} > {ax, 1'b0}) && (ay >= cfg.swipe_min_move);
        if (still && held >= TIME_W'(cfg.long_press_ms)) return GEST_LONG;
        if (still && held < TIME_W'(cfg.tap_max_ms)) return GEST_TAP;
        if (horiz) return (trk.last_x > trk.first_x) ? GEST_RIGHT : GEST_LEFT;
        if (vert) return (trk.last_y > trk.first_y) ? GEST_DOWN : GEST_UP;
        return GEST_NONE;
    endfunction

    // Advance the shadow state by one poll and give its outcome
    function automatic t_outcome predict_poll(t_sample s);
        t_outcome r;
        logic     in_bounds;
        r = '{gesture: GEST_NONE, rejected: 1'b0, origin_y: '0};
        if (cfg.enable) begin
            in_bounds = (s.pos_x != 0) && (s.pos_x < cfg.x_edge) &&
                        (s.pos_y != 0) && (s.pos_y < cfg.y_edge);
            if (s.pressed && !in_bounds) begin
                r.rejected = 1'b1;
            end else if (s.pressed) begin
                if (!touching) begin
                    trk.first_x    = s.pos_x;
                    trk.first_y    = s.pos_y;
                    trk.press_time = s.now_ms;
                    touching       = 1'b1;
                end
                trk.last_x = s.pos_x;
                trk.last_y = s.pos_y;
            end else if (touching) begin
                r.gesture  = classify_release(s.now_ms);
                r.origin_y = trk.first_y;
                touching   = 1'b0;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_outcome want;
        if (!i_rst_n) begin
            cfg = '{enable: 1'b1, x_edge: X_EDGE_RST, y_edge: Y_EDGE_RST,
                    long_press_ms: LONG_PRESS_MS_RST, tap_max_ms: TAP_MAX_MS_RST,
                    tap_max_move: TAP_MAX_MOVE_RST, swipe_min_move: SWIPE_MIN_MOVE_RST};
            touching = 1'b0;
            trk      = '0;
            expected_outcomes.delete();
            fail_count = 0;
        end else begin
            // Sample transfer: predict its outcome
            if (i_sample.valid && i_sample.ready) begin
                expected_outcomes.push_back(predict_poll('{pressed: i_sample.pressed,
                    pos_x: i_sample.pos_x, pos_y: i_sample.pos_y,
                    now_ms: i_sample.now_ms}));
            end
            // Result transfer: compare with the oldest outcome
            if (i_result.valid && i_result.ready) begin
                if (expected_outcomes.size() == 0) begin
                    $display("%0t: result with nothing expected: gesture %0d rejected %0d",
                             $time, i_result.gesture, i_result.rejected);
                    fail_count++;
                end else begin
                    want = expected_outcomes.pop_front();
                    if (want.gesture !== i_result.gesture) begin
                        $display("%0t: gesture mismatch: expected %0d, actual %0d",
                                 $time, want.gesture, i_result.gesture);
                        fail_count++;
                    end
                    if (want.rejected !== i_result.rejected) begin
                        $display("%0t: rejected mismatch: expected %0d, actual %0d",
                                 $time, want.rejected, i_result.rejected);
                        fail_count++;
                    end
                    if (want.origin_y !== i_result.origin_y) begin
                        $display("%0t: origin_y mismatch: expected %0d, actual %0d",
                                 $time, want.origin_y, i_result.origin_y);
                        fail_count++;
                    end
                end
            end
            // Register writes
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_ENABLE:         cfg.enable         = i_cfg_data[0];
                    CFG_X_EDGE:         cfg.x_edge         = i_cfg_data;
                    CFG_Y_EDGE:         cfg.y_edge         = i_cfg_data;
                    CFG_LONG_PRESS_MS:  cfg.long_press_ms  = i_cfg_data;
                    CFG_TAP_MAX_MS:     cfg.tap_max_ms     = i_cfg_data;
                    CFG_TAP_MAX_MOVE:   cfg.tap_max_move   = i_cfg_data;
                    CFG_SWIPE_MIN_MOVE: cfg.swipe_min_move = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_outcomes.size();
    end

endmodule

// ----- test/tb_top.sv -----
module tb_top;
    import tgc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;
    int                   fails;
    int                   pending;
    int                   cycles = 0;

    // Shared between the stimulus and the receiver
    logic                 idle_on = 1'b0;
    int                   hold_req = 0;

    // Stimulus bookkeeping
    t_cfg                 cur_cfg;
    logic [TIME_W-1:0]    clock_ms;
    int                   n_sent = 0;

    tgc_sample_if sample_ch ();
    tgc_result_if result_ch ();

    touch_gesture_classifier_top u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_sample   (sample_ch),
        .o_result   (result_ch)
    );

    tgc_gesture_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_sample     (sample_ch),
        .i_result     (result_ch),
        .o_fail_count (fails),
        .o_pending    (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("touch_gesture_classifier_top regression: fail");
            $finish;
        end
    end

    // Result side: random stalls, plus long hold-offs on request
    initial begin : receiver
        int hold_left;
        int holds_seen;
        hold_left  = 0;
        holds_seen = 0;
        result_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req != holds_seen) begin
                holds_seen = hold_req;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end else if (idle_on) begin
                result_ch.ready <= ($urandom_range(99) >= 32);
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // One sample transfer, with an optional gap in front
    task automatic put_sample(input logic p, input logic [COORD_W-1:0] x,
                              input logic [COORD_W-1:0] y, input logic [TIME_W-1:0] t);
        if (idle_on && $urandom_range(99) < 32) begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        sample_ch.valid   <= 1'b1;
        sample_ch.pressed <= p;
        sample_ch.pos_x   <= x;
        sample_ch.pos_y   <= y;
        sample_ch.now_ms  <= t;
        do @(posedge clk); while (!(sample_ch.valid && sample_ch.ready));
        n_sent++;
    endtask

    // Stop offering and wait for every outstanding result
    task automatic wait_drained();
        sample_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    // Full register set, written only once the block is idle
    task automatic apply_cfg(input t_cfg c);
        wait_drained();
        put_reg(CFG_ENABLE, CFG_W'(c.enable));
        put_reg(CFG_X_EDGE, c.x_edge);
        put_reg(CFG_Y_EDGE, c.y_edge);
        put_reg(CFG_LONG_PRESS_MS, c.long_press_ms);
        put_reg(CFG_TAP_MAX_MS, c.tap_max_ms);
        put_reg(CFG_TAP_MAX_MOVE, c.tap_max_move);
        put_reg(CFG_SWIPE_MIN_MOVE, c.swipe_min_move);
        cfg_we <= 1'b0;
        cur_cfg = c;
    endtask

    function automatic t_cfg random_cfg();
        t_cfg c;
        c.enable         = 1'b1;
        c.x_edge         = COORD_W'($urandom_range(2000, 50));
        c.y_edge         = COORD_W'($urandom_range(2000, 50));
        c.long_press_ms  = CFG_W'($urandom_range(3000, 300));
        c.tap_max_ms     = CFG_W'($urandom_range(600, 20));
        c.tap_max_move   = CFG_W'($urandom_range(60, 2));
        c.swipe_min_move = CFG_W'($urandom_range(200, 5));
        return c;
    endfunction

    function automatic int pick_inside(int lim);
        if (lim < 2) return int'($urandom_range(65535));
        return int'($urandom_range(lim - 1, 1));
    endfunction

    function automatic int fit(int v, int lim);
        if (lim < 2) return v & 16'hFFFF;
        if (v < 1) return 1;
        if (v > lim - 1) return lim - 1;
        return v;
    endfunction

    function automatic int jitter(int m);
        return int'($urandom_range(2 * m)) - m;
    endfunction

    // Either hugging a threshold or anywhere up to somewhat past it
    function automatic int near(int v);
        int r;
        if ($urandom_range(1)) r = v - 3 + int'($urandom_range(6));
        else r = int'($urandom_range(v + 300));
        return (r < 0) ? 0 : r;
    endfunction

    // Pressed poll that falls outside the open bounds on at least one axis
    task automatic send_outside(input logic [TIME_W-1:0] t);
        int xe;
        int ye;
        xe = cur_cfg.x_edge;
        ye = cur_cfg.y_edge;
        case ($urandom_range(3))
            0: put_sample(1'b1, 16'd0, COORD_W'($urandom), t);
            1: put_sample(1'b1, COORD_W'($urandom), 16'd0, t);
            2: put_sample(1'b1, COORD_W'($urandom_range(65535, xe)), COORD_W'($urandom), t);
            default: put_sample(1'b1, COORD_W'($urandom), COORD_W'($urandom_range(65535, ye)), t);
        endcase
    endtask

    // Press, a few held polls towards a target, then usually a release
    task automatic send_gesture();
        int xe;
        int ye;
        int x0;
        int y0;
        int x1;
        int y1;
        int mag;
        int dur;
        int n_hold;
        logic [TIME_W-1:0] t0;
        xe = cur_cfg.x_edge;
        ye = cur_cfg.y_edge;
        x0 = pick_inside(xe);
        y0 = pick_inside(ye);
        case ($urandom_range(3))
            0: begin
                x1 = x0 + jitter(cur_cfg.tap_max_move);
                y1 = y0 + jitter(cur_cfg.tap_max_move);
            end
            1: begin
                mag = near(cur_cfg.swipe_min_move);
                x1  = $urandom_range(1) ? x0 + mag : x0 - mag;
                y1  = y0 + jitter(mag / 2 + 1);
            end
            2: begin
                mag = near(cur_cfg.swipe_min_move);
                y1  = $urandom_range(1) ? y0 + mag : y0 - mag;
                x1  = x0 + jitter(mag / 2 + 1);
            end
            default: begin
                x1 = pick_inside(xe);
                y1 = pick_inside(ye);
            end
        endcase
        x1 = fit(x1, xe);
        y1 = fit(y1, ye);
        case ($urandom_range(2))
            0: dur = near(cur_cfg.tap_max_ms);
            1: dur = near(cur_cfg.long_press_ms);
            default: dur = int'($urandom_range(cur_cfg.long_press_ms + 200));
        endcase
        t0 = clock_ms;
        put_sample(1'b1, COORD_W'(x0), COORD_W'(y0), t0);
        n_hold = $urandom_range(3);
        for (int k = 1; k <= n_hold; k++) begin
            if ($urandom_range(99) < 20) send_outside(t0 + TIME_W'(dur * k / (n_hold + 1)));
            put_sample(1'b1, COORD_W'(x0 + (x1 - x0) * k / n_hold),
                       COORD_W'(y0 + (y1 - y0) * k / n_hold),
                       t0 + TIME_W'(dur * k / (n_hold + 1)));
        end
        // Now and then the release goes missing and the next press joins in
        if ($urandom_range(99) < 92)
            put_sample(1'b0, COORD_W'($urandom), COORD_W'($urandom), t0 + TIME_W'(dur));
        clock_ms = t0 + TIME_W'(dur) + TIME_W'($urandom_range(40, 1));
        if ($urandom_range(99) < 3) clock_ms = $urandom();
        else if ($urandom_range(99) < 2) clock_ms = 32'hFFFF_FFFF - $urandom_range(3000);
    endtask

    initial begin : stimulus
        t_cfg c;
        int   quota;
        int   target;
        logic paused;

        rst_n    = 1'b0;
        cfg_we   = 1'b0;
        cfg_idx  = CFG_ENABLE;
        cfg_data = '0;
        sample_ch.valid   = 1'b0;
        sample_ch.pressed = 1'b0;
        sample_ch.pos_x   = '0;
        sample_ch.pos_y   = '0;
        sample_ch.now_ms  = '0;
        cur_cfg = '{enable: 1'b1, x_edge: X_EDGE_RST, y_edge: Y_EDGE_RST,
                    long_press_ms: LONG_PRESS_MS_RST, tap_max_ms: TAP_MAX_MS_RST,
                    tap_max_move: TAP_MAX_MOVE_RST, swipe_min_move: SWIPE_MIN_MOVE_RST};
        clock_ms = 32'd100000;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part on the reset register values
        idle_on = 1'b1;
        put_sample(1'b0, 16'd10, 16'd10, 32'd100);           // release with no touch
        put_sample(1'b1, 16'd1, 16'd1, 32'd1000);            // tap at the lowest corner
        put_sample(1'b0, 16'd0, 16'd0, 32'd1100);
        put_sample(1'b1, 16'd278, 16'd454, 32'd2000);        // long press, exactly at limit
        put_sample(1'b0, 16'hFFFF, 16'hFFFF, 32'd3000);
        put_sample(1'b1, 16'd100, 16'd200, 32'd4000);        // right, rejects in between
        put_sample(1'b1, 16'd279, 16'd100, 32'd4010);
        put_sample(1'b1, 16'd100, 16'd455, 32'd4020);
        put_sample(1'b1, 16'd160, 16'd210, 32'd4100);
        put_sample(1'b0, 16'd0, 16'd0, 32'd4200);
        put_sample(1'b1, 16'd200, 16'd200, 32'd5000);        // left
        put_sample(1'b1, 16'd100, 16'd190, 32'd5100);
        put_sample(1'b0, 16'd0, 16'd0, 32'd5200);
        put_sample(1'b1, 16'd100, 16'd100, 32'd6000);        // down
        put_sample(1'b1, 16'd110, 16'd200, 32'd6100);
        put_sample(1'b0, 16'd0, 16'd0, 32'd6200);
        put_sample(1'b1, 16'd100, 16'd300, 32'd7000);        // up
        put_sample(1'b1, 16'd95, 16'd200, 32'd7100);
        put_sample(1'b0, 16'd0, 16'd0, 32'd7200);
        put_sample(1'b1, 16'd100, 16'd100, 32'd8000);        // dx is exactly twice dy
        put_sample(1'b1, 16'd200, 16'd150, 32'd8100);
        put_sample(1'b0, 16'd0, 16'd0, 32'd8200);
        put_sample(1'b1, 16'd50, 16'd50, 32'd9500);          // hold equal to the tap limit
        put_sample(1'b0, 16'd0, 16'd0, 32'd9800);
        put_sample(1'b1, 16'd20, 16'd30, 32'hFFFF_FFF0);     // hold time across the wrap
        put_sample(1'b0, 16'd0, 16'd0, 32'h0000_0050);
        // Touch held across a disabled stretch
        put_sample(1'b1, 16'd10, 16'd20, 32'd20000);
        c = cur_cfg;
        c.enable = 1'b0;
        apply_cfg(c);
        put_sample(1'b0, 16'd0, 16'd0, 32'd20100);
        put_sample(1'b1, 16'd200, 16'd300, 32'd20200);
        c.enable = 1'b1;
        apply_cfg(c);
        put_sample(1'b0, 16'd0, 16'd0, 32'd20250);

        // Random phases, the register extremes among them
        for (int ph = 0; ph < 7; ph++) begin
            c       = random_cfg();
            quota   = 160;
            idle_on = 1'b1;
            paused  = 1'b0;
            case (ph)
                1: idle_on = 1'b0;
                2: c = '{enable: 1'b1, x_edge: '1, y_edge: '1, long_press_ms: '1,
                         tap_max_ms: '1, tap_max_move: '1, swipe_min_move: '1};
                3: begin
                    c = '{enable: 1'b1, x_edge: 16'd1, y_edge: 16'd0, long_press_ms: '0,
                          tap_max_ms: '0, tap_max_move: '0, swipe_min_move: '0};
                    quota = 60;
                end
                4: begin
                    c = '{enable: 1'b1, x_edge: 16'd2, y_edge: 16'd2, long_press_ms: '0,
                          tap_max_ms: '0, tap_max_move: '0, swipe_min_move: '0};
                    quota = 60;
                end
                default: ;
            endcase
            apply_cfg(c);
            if (ph == 0 || ph == 5) hold_req++;
            target = n_sent + quota;
            while (n_sent < target) begin
                if (ph == 2 && !paused && n_sent >= target - quota / 2) begin
                    wait_drained();
                    paused = 1'b1;
                end
                if ($urandom_range(99) < 80) begin
                    send_gesture();
                end else begin
                    put_sample($urandom_range(1), COORD_W'($urandom), COORD_W'($urandom),
                               $urandom_range(1) ? TIME_W'($urandom()) : clock_ms);
                end
            end
        end

        wait_drained();
        if (fails == 0 && pending == 0) begin
            $display("touch_gesture_classifier_top regression: pass");
        end else begin
            $display("touch_gesture_classifier_top regression: fail");
        end
        $finish;
    end

endmodule
